>>> hdl/bfha_pkg.sv
package bfha_pkg;

  localparam int REQ_W = 12;
  localparam int OFF_W = 12;
  localparam int WORD_W = 32;

  localparam int DEF_HEAP_BYTES = 4096;
  localparam int DEF_ALIGN_BYTES = 16;
  localparam int DEF_HEADER_BYTES = 8;

  // header word: size << 2 | prev-busy << 1 | busy
  localparam logic [WORD_W-1:0] FLAG_BUSY = 32'h0000_0001;
  localparam logic [WORD_W-1:0] FLAG_PREVBUSY = 32'h0000_0002;
  localparam logic [WORD_W-1:0] END_MARK = 32'h0000_0001;

  typedef enum logic [3:0] {
    ST_INIT_HDR,
    ST_INIT_FTR,
    ST_INIT_END,
    ST_IDLE,
    ST_CALC,
    ST_SCALE,
    ST_RD,
    ST_CHK,
    ST_WR_HDR,
    ST_WR_REM,
    ST_WR_FTR,
    ST_DONE
  } bfha_state_e;

  // bits that hold the rounded block size of any request
  function automatic int need_width(int hdr_bytes, int align_bytes);
    return $clog2((1 << REQ_W) + hdr_bytes + align_bytes);
  endfunction

endpackage

>>> hdl/bfha_ram.sv
module bfha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bfha_round.sv
module bfha_round
  import bfha_pkg::*;
#(
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
  input  logic                                              clk_i,
  input  logic [REQ_W-1:0]                                  req_bytes_i,
  output logic [need_width(HEADER_BYTES, ALIGN_BYTES)-1:0]  need_o
);

  localparam int NW = need_width(HEADER_BYTES, ALIGN_BYTES);
  localparam int L = $clog2(ALIGN_BYTES);
  localparam int S = NW + L;
  localparam int MW = S - L + 2;
  localparam int MUL = (2 ** S + ALIGN_BYTES - 1) / ALIGN_BYTES;

  logic [NW-1:0]    x;
  logic [NW+MW-1:0] prod_q;
  logic [NW-1:0]    quot;
  logic [NW-1:0]    need_q;

  // ceiling division by the alignment via a reciprocal that is exact below 2**NW
  assign x = NW'(req_bytes_i) + NW'(HEADER_BYTES + ALIGN_BYTES - 1);
  assign quot = NW'(prod_q >> S);

  always_ff @(posedge clk_i) begin
    prod_q <= (NW+MW)'(x) * (NW+MW)'(MW'(MUL));
    need_q <= NW'(quot * NW'(ALIGN_BYTES));
  end

  assign need_o = need_q;

endmodule

>>> hdl/bfha_ctrl.sv
module bfha_ctrl
  import bfha_pkg::*;
#(
  parameter int HEAP_BYTES = DEF_HEAP_BYTES,
  parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             start,
  output logic                                             busy,
  input  logic [REQ_W-1:0]                                 request_bytes_i,
  output logic [REQ_W-1:0]                                 req_bytes_o,
  input  logic [need_width(HEADER_BYTES, ALIGN_BYTES)-1:0] need_i,
  output logic                                             mem_we_o,
  output logic [$clog2(HEAP_BYTES/4)-1:0]                  mem_waddr_o,
  output logic [WORD_W-1:0]                                mem_wdata_o,
  output logic [$clog2(HEAP_BYTES/4)-1:0]                  mem_raddr_o,
  input  logic [WORD_W-1:0]                                mem_rdata_i,
  output logic                                             result_valid_o,
  output logic                                             granted_o,
  output logic [OFF_W-1:0]                                 payload_offset_o
);

  localparam int AW = $clog2(HEAP_BYTES + 1);
  localparam int WIX = $clog2(HEAP_BYTES / 4);
  localparam int ITER_MAX = HEAP_BYTES / ALIGN_BYTES;
  localparam int ITW = $clog2(ITER_MAX + 2);
  localparam int SZW = WORD_W - 2;
  localparam int FIRST =
    ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES - HEADER_BYTES;
  localparam int RSIZE = (HEAP_BYTES > FIRST + HEADER_BYTES) ?
    ((HEAP_BYTES - FIRST - HEADER_BYTES) / ALIGN_BYTES) * ALIGN_BYTES : 0;
  localparam int FTR_BYTE = (RSIZE > 0) ? FIRST + RSIZE - 4 : 0;
  localparam logic [WORD_W-1:0] INIT_HDR_WORD =
    (WORD_W'(RSIZE) << 2) | FLAG_PREVBUSY;
  localparam bfha_state_e RESET_STATE = (RSIZE > 0) ? ST_INIT_HDR : ST_INIT_END;

  bfha_state_e state_q, state_d;

  logic [REQ_W-1:0] req_q, req_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [ITW-1:0]   iter_q, iter_d;
  logic [AW-1:0]    best_q, best_d;
  logic [AW-1:0]    bsize_q, bsize_d;
  logic             bprev_q, bprev_d;
  logic             found_q, found_d;

  logic [SZW-1:0] bsz;
  logic [AW-1:0]  room;
  logic           chk_end;
  logic           chk_exact;
  logic           chk_better;
  logic           rd_stop;
  logic           split;
  logic [AW-1:0]  rem;
  logic [AW:0]    poff;

  // block under inspection
  assign bsz = mem_rdata_i[WORD_W-1:2];
  assign room = AW'(HEAP_BYTES) - cur_q;
  assign chk_end = (mem_rdata_i == END_MARK) || (bsz == '0) || (bsz > SZW'(room));
  assign chk_exact = !mem_rdata_i[0] && (bsz == SZW'(need_i));
  assign chk_better = !mem_rdata_i[0] && (bsz > SZW'(need_i)) &&
                      (!found_q || (bsz < SZW'(bsize_q)));

  assign rd_stop = (({1'b0, cur_q} + (AW+1)'(4)) > (AW+1)'(HEAP_BYTES)) ||
                   (iter_q > ITW'(ITER_MAX));

  assign split = SZW'(bsize_q) > SZW'(need_i);
  assign rem = bsize_q - AW'(need_i);
  assign poff = (AW+1)'(best_q) + (AW+1)'(HEADER_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RESET_STATE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    cur_q   <= cur_d;
    iter_q  <= iter_d;
    best_q  <= best_d;
    bsize_q <= bsize_d;
    bprev_q <= bprev_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT_HDR: state_d = ST_INIT_FTR;
      ST_INIT_FTR: state_d = ST_INIT_END;
      ST_INIT_END: state_d = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_d = (request_bytes_i == '0) ? ST_DONE : ST_CALC;
        end
      end
      ST_CALC:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_RD;
      ST_RD: begin
        if (rd_stop) begin
          state_d = found_q ? ST_WR_HDR : ST_DONE;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (chk_end) begin
          state_d = found_q ? ST_WR_HDR : ST_DONE;
        end else if (chk_exact) begin
          state_d = ST_WR_HDR;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_WR_HDR: state_d = split ? ST_WR_REM : ST_DONE;
      ST_WR_REM: state_d = ST_WR_FTR;
      ST_WR_FTR: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // walk datapath
  always_comb begin
    req_d   = req_q;
    cur_d   = cur_q;
    iter_d  = iter_q;
    best_d  = best_q;
    bsize_d = bsize_q;
    bprev_d = bprev_q;
    found_d = found_q;
    if (state_q == ST_IDLE && start) begin
      req_d   = request_bytes_i;
      cur_d   = AW'(FIRST);
      iter_d  = '0;
      found_d = 1'b0;
    end
    if (state_q == ST_CHK && !chk_end) begin
      if (chk_exact || chk_better) begin
        best_d  = cur_q;
        bsize_d = AW'(bsz);
        bprev_d = mem_rdata_i[1];
        found_d = 1'b1;
      end
      if (!chk_exact) begin
        cur_d  = cur_q + AW'(bsz);
        iter_d = iter_q + ITW'(1);
      end
    end
  end

  // memory and result outputs
  always_comb begin
    mem_we_o         = 1'b0;
    mem_waddr_o      = WIX'(best_q >> 2);
    mem_wdata_o      = '0;
    result_valid_o   = 1'b0;
    granted_o        = 1'b0;
    payload_offset_o = '0;
    case (state_q)
      ST_INIT_HDR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = WIX'(FIRST / 4);
        mem_wdata_o = INIT_HDR_WORD;
      end
      ST_INIT_FTR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = WIX'(FTR_BYTE / 4);
        mem_wdata_o = WORD_W'(RSIZE);
      end
      ST_INIT_END: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = WIX'((FIRST + RSIZE) / 4);
        mem_wdata_o = END_MARK;
      end
      ST_WR_HDR: begin
        mem_we_o = 1'b1;
        if (split) begin
          mem_wdata_o = (WORD_W'(need_i) << 2) | FLAG_BUSY |
                        (bprev_q ? FLAG_PREVBUSY : '0);
        end else begin
          mem_wdata_o = (WORD_W'(bsize_q) << 2) | FLAG_BUSY |
                        (bprev_q ? FLAG_PREVBUSY : '0);
        end
      end
      ST_WR_REM: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = WIX'((best_q + AW'(need_i)) >> 2);
        mem_wdata_o = (WORD_W'(rem) << 2) | FLAG_PREVBUSY;
      end
      ST_WR_FTR: begin
        // size footer in the last word of the free remainder
        mem_we_o    = 1'b1;
        mem_waddr_o = WIX'((best_q + bsize_q - AW'(4)) >> 2);
        mem_wdata_o = WORD_W'(rem);
      end
      ST_DONE: begin
        result_valid_o   = 1'b1;
        granted_o        = found_q;
        payload_offset_o = found_q ? OFF_W'(poff) : '0;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  assign mem_raddr_o = WIX'(cur_q >> 2);
  assign req_bytes_o = req_q;
  assign busy = (state_q != ST_IDLE);

endmodule

>>> hdl/best_fit_heap_allocator.sv
// sequence: a zero request goes straight from idle to the result state; otherwise calc,
//   scale, then a read and a check state per header read (end mark included), then 0, 1
//   or 3 heap writes, with one read of the heap ram per block (registered read port) and
//   one write per cycle; a walk cut off at the block limit ends on a read with no check
// throughput: one request at a time, start is taken again the cycle after the result strobe
// reset: busy is high while the initial free block, its footer and the end
//   mark are written; the result receiver cannot stall
module best_fit_heap_allocator
  import bfha_pkg::*;
#(
  parameter int HEAP_BYTES = DEF_HEAP_BYTES,
  parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [REQ_W-1:0] request_bytes_i,
  output logic             result_valid_o,
  output logic             granted_o,
  output logic [OFF_W-1:0] payload_offset_o
);

  localparam int NW = need_width(HEADER_BYTES, ALIGN_BYTES);
  localparam int DEPTH = HEAP_BYTES / 4;
  localparam int WIX = $clog2(DEPTH);

  logic [REQ_W-1:0]  req_bytes;
  logic [NW-1:0]     need;
  logic              mem_we;
  logic [WIX-1:0]    mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WIX-1:0]    mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  bfha_round #(
    .HEADER_BYTES(HEADER_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_round (
    .clk_i      (clk_i),
    .req_bytes_i(req_bytes),
    .need_o     (need)
  );

  bfha_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_heap (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  bfha_ctrl #(
    .HEAP_BYTES  (HEAP_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .request_bytes_i (request_bytes_i),
    .req_bytes_o     (req_bytes),
    .need_i          (need),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .result_valid_o  (result_valid_o),
    .granted_o       (granted_o),
    .payload_offset_o(payload_offset_o)
  );

endmodule

>>> hdl/bfha_checker.sv
module bfha_checker
  import bfha_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [REQ_W-1:0] request_bytes_i,
  input logic             result_valid_o,
  input logic             granted_o,
  input logic [OFF_W-1:0] payload_offset_o
);

  // a result only closes a request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // one strobe per request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !granted_o) |-> (payload_offset_o == '0))
    else $error("refused request with nonzero offset");

  // zero size is refused right away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (request_bytes_i == '0)) |=> (result_valid_o && !granted_o))
    else $error("zero request not refused at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (.*);
